// ===== hdl/fac_pkg.sv =====
package fac_pkg;

  typedef enum logic [2:0] {
    ST_OUT    = 3'd0,
    ST_COLD   = 3'd1,
    ST_SWOFF  = 3'd2,
    ST_HEAT   = 3'd3,
    ST_SETTLE = 3'd4,
    ST_COOL   = 3'd5
  } fsm_state_t;

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_HELIUM_DRY_LIMIT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STILL_HOT_START   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SWITCH_COLD_LIMIT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PUMP_MAX_LIMIT    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COLD_PLATE_SET    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STILL_COLD_DONE   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_HEAT_TIMEOUT_S    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_COOL_TIMEOUT_S    = 3'd7;

  localparam logic [15:0] RST_HELIUM_DRY_LIMIT  = 16'd5000;
  localparam logic [15:0] RST_STILL_HOT_START   = 16'd600;
  localparam logic [15:0] RST_SWITCH_COLD_LIMIT = 16'd10000;
  localparam logic [15:0] RST_PUMP_MAX_LIMIT    = 16'd38000;
  localparam logic [15:0] RST_COLD_PLATE_SET    = 16'd1800;
  localparam logic [15:0] RST_STILL_COLD_DONE   = 16'd350;
  localparam logic [15:0] RST_HEAT_TIMEOUT_S    = 16'd2100;
  localparam logic [15:0] RST_COOL_TIMEOUT_S    = 16'd7200;

  // Fixed timeouts in seconds.
  localparam logic [31:0] SWITCH_TIMEOUT_S = 32'd300;
  localparam logic [31:0] SETTLE_MIN_S     = 32'd300;
  localparam logic [31:0] SETTLE_TIMEOUT_S = 32'd5400;

  typedef struct packed {
    logic [15:0] helium_dry_limit;
    logic [15:0] still_hot_start;
    logic [15:0] switch_cold_limit;
    logic [15:0] pump_max_limit;
    logic [15:0] cold_plate_set;
    logic [15:0] still_cold_done;
    logic [15:0] heat_timeout_s;
    logic [15:0] cool_timeout_s;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  channel;
    logic [31:0] now_seconds;
    logic [15:0] temp_4k_mk;
    logic [15:0] temp_cold_plate_mk;
    logic [15:0] temp_pump_mk;
    logic [15:0] temp_still_mk;
    logic [15:0] temp_switch_mk;
    logic        force_request;
    logic        manual_mode;
  } item_t;

  typedef struct packed {
    fsm_state_t  state;
    logic [31:0] cycle_start_time;
    logic [31:0] state_entry_time;
    logic        force_pending;
  } chan_rec_t;

  typedef struct packed {
    logic       pump_heat_on;
    logic       switch_drive_off;
    fsm_state_t fsm_state;
  } result_t;

endpackage

// ===== hdl/fac_regs.sv =====
module fac_regs
  import fac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.helium_dry_limit  <= RST_HELIUM_DRY_LIMIT;
      cfg.still_hot_start   <= RST_STILL_HOT_START;
      cfg.switch_cold_limit <= RST_SWITCH_COLD_LIMIT;
      cfg.pump_max_limit    <= RST_PUMP_MAX_LIMIT;
      cfg.cold_plate_set    <= RST_COLD_PLATE_SET;
      cfg.still_cold_done   <= RST_STILL_COLD_DONE;
      cfg.heat_timeout_s    <= RST_HEAT_TIMEOUT_S;
      cfg.cool_timeout_s    <= RST_COOL_TIMEOUT_S;
    end else if (wr_en) begin
      unique case (idx)
        REG_HELIUM_DRY_LIMIT:  cfg.helium_dry_limit  <= pwdata[15:0];
        REG_STILL_HOT_START:   cfg.still_hot_start   <= pwdata[15:0];
        REG_SWITCH_COLD_LIMIT: cfg.switch_cold_limit <= pwdata[15:0];
        REG_PUMP_MAX_LIMIT:    cfg.pump_max_limit    <= pwdata[15:0];
        REG_COLD_PLATE_SET:    cfg.cold_plate_set    <= pwdata[15:0];
        REG_STILL_COLD_DONE:   cfg.still_cold_done   <= pwdata[15:0];
        REG_HEAT_TIMEOUT_S:    cfg.heat_timeout_s    <= pwdata[15:0];
        REG_COOL_TIMEOUT_S:    cfg.cool_timeout_s    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HELIUM_DRY_LIMIT:  prdata = {16'd0, cfg.helium_dry_limit};
      REG_STILL_HOT_START:   prdata = {16'd0, cfg.still_hot_start};
      REG_SWITCH_COLD_LIMIT: prdata = {16'd0, cfg.switch_cold_limit};
      REG_PUMP_MAX_LIMIT:    prdata = {16'd0, cfg.pump_max_limit};
      REG_COLD_PLATE_SET:    prdata = {16'd0, cfg.cold_plate_set};
      REG_STILL_COLD_DONE:   prdata = {16'd0, cfg.still_cold_done};
      REG_HEAT_TIMEOUT_S:    prdata = {16'd0, cfg.heat_timeout_s};
      REG_COOL_TIMEOUT_S:    prdata = {16'd0, cfg.cool_timeout_s};
      default:               prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/fac_step.sv =====
module fac_step
  import fac_pkg::*;
(
  input  item_t     item,
  input  chan_rec_t rec,
  input  cfg_t      cfg,
  output chan_rec_t rec_next,
  output result_t   res
);

  logic [31:0] since_start;
  logic [31:0] since_entry;
  fsm_state_t  state_next;

  assign since_start = item.now_seconds - rec.cycle_start_time;
  assign since_entry = item.now_seconds - rec.state_entry_time;

  always_comb begin
    rec_next               = rec;
    rec_next.force_pending = rec.force_pending | item.force_request;
    state_next             = rec.state;
    if (item.manual_mode) begin
      state_next = ST_OUT;
    end else if (item.temp_4k_mk > cfg.helium_dry_limit) begin
      state_next = ST_OUT;
    end else begin
      unique case (rec.state)
        ST_OUT: begin
          if (item.temp_4k_mk < cfg.helium_dry_limit) begin
            state_next = ST_COLD;
          end
        end
        ST_COLD: begin
          if (item.temp_still_mk > cfg.still_hot_start || rec_next.force_pending) begin
            rec_next.force_pending    = 1'b0;
            rec_next.cycle_start_time = item.now_seconds;
            rec_next.state_entry_time = item.now_seconds;
            state_next                = ST_SWOFF;
          end
        end
        ST_SWOFF: begin
          if (item.temp_switch_mk < cfg.switch_cold_limit
              || since_start > SWITCH_TIMEOUT_S) begin
            rec_next.state_entry_time = item.now_seconds;
            state_next                = ST_HEAT;
          end
        end
        ST_HEAT: begin
          if (since_start > {16'd0, cfg.heat_timeout_s}
              || item.temp_pump_mk > cfg.pump_max_limit) begin
            rec_next.state_entry_time = item.now_seconds;
            state_next                = ST_SETTLE;
          end
        end
        ST_SETTLE: begin
          if (since_entry > SETTLE_MIN_S && (item.temp_cold_plate_mk < cfg.cold_plate_set
              || since_start > SETTLE_TIMEOUT_S)) begin
            rec_next.state_entry_time = item.now_seconds;
            state_next                = ST_COOL;
          end
        end
        ST_COOL: begin
          if (item.temp_still_mk < cfg.still_cold_done
              || since_start > {16'd0, cfg.cool_timeout_s}) begin
            rec_next.force_pending    = 1'b0;
            rec_next.state_entry_time = item.now_seconds;
            state_next                = ST_COLD;
          end
        end
        default: state_next = ST_COLD;
      endcase
    end
    rec_next.state = state_next;
  end

  always_comb begin
    res.fsm_state        = state_next;
    res.pump_heat_on     = (state_next == ST_HEAT);
    res.switch_drive_off = (state_next == ST_SWOFF) || (state_next == ST_HEAT)
                           || (state_next == ST_SETTLE);
  end

endmodule

// ===== hdl/fridge_auto_cycle_fsm_core.sv =====
// Auto-cycle controller for up to NUM_CHANNELS helium-3 fridge inserts. Each stream transaction
// carries one update for one channel and yields exactly one result transaction with the pump
// heater bit, the heat-switch off bit and the new cycle state. An update is registered on
// entry, evaluated against that channel's stored state and written to the output register, so
// one update per clock is sustained unless the output stalls, and updates for the same channel
// may follow each other directly. Updates in manual mode or for a channel at or above
// NUM_CHANNELS give an all-zero result; the latter change no state. The user must write
// thresholds and timeouts (APB byte address 4*i) only while no update is in flight; unenforced.
module fridge_auto_cycle_fsm_core
  import fac_pkg::*;
#(
  parameter int NUM_CHANNELS = 6
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // now_seconds[31:0], temp_4k_mk[47:32], temp_cold_plate_mk[63:48], temp_pump_mk[79:64],
  // temp_still_mk[95:80], temp_switch_mk[111:96], force_request[112], manual_mode[113]
  input  logic [119:0] s_axis_tdata,
  // channel[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pump_heat_on[0], switch_drive_off[1], fsm_state[4:2]
  output logic [7:0]   m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t      cfg;
  item_t     item;
  logic      in_valid;
  logic      advance;
  logic      ch_in_range;
  logic [4:0] ch_ext;
  chan_rec_t chan [NUM_CHANNELS];
  chan_rec_t rec_cur;
  chan_rec_t rec_next;
  result_t   res;
  result_t   out_res;

  fac_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.channel            <= s_axis_tuser;
      item.now_seconds        <= s_axis_tdata[31:0];
      item.temp_4k_mk         <= s_axis_tdata[47:32];
      item.temp_cold_plate_mk <= s_axis_tdata[63:48];
      item.temp_pump_mk       <= s_axis_tdata[79:64];
      item.temp_still_mk      <= s_axis_tdata[95:80];
      item.temp_switch_mk     <= s_axis_tdata[111:96];
      item.force_request      <= s_axis_tdata[112];
      item.manual_mode        <= s_axis_tdata[113];
    end
  end

  assign ch_ext      = {2'b00, item.channel};
  assign ch_in_range = ch_ext < 5'(NUM_CHANNELS);

  always_comb begin
    rec_cur = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (ch_ext == 5'(i)) begin
        rec_cur = chan[i];
      end
    end
  end

  fac_step u_step (
    .item     (item),
    .rec      (rec_cur),
    .cfg      (cfg),
    .rec_next (rec_next),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan[i] <= '0;
      end
    end else if (advance && ch_in_range) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (ch_ext == 5'(i)) begin
          chan[i] <= rec_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= ch_in_range ? res : '0;
    end
  end

  assign m_axis_tdata = {3'b000, out_res.fsm_state, out_res.switch_drive_off,
                         out_res.pump_heat_on};

`ifndef SYNTHESIS
  a_manual_gives_out: assert property (@(posedge clk) disable iff (rst)
    (advance && item.manual_mode) |=> (m_axis_tvalid && m_axis_tdata == 8'd0))
    else $error("Manual update did not give an all-zero result.");

  a_range_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (advance && !ch_in_range) |=> (m_axis_tvalid && m_axis_tdata == 8'd0))
    else $error("Update for an absent channel did not give an all-zero result.");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(item)))
    else $error("Input stage lost a stalled update.");

  a_heat_implies_switch_off: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[1] && out_res.fsm_state == ST_HEAT))
    else $error("Pump heater on outside the heating state.");
`endif

endmodule
